// ===== rtl/polynomial_map_orbit_jacobian_top_assert.svh =====
// Assertion macros for the orbit block
`ifndef POLYNOMIAL_MAP_ORBIT_JACOBIAN_TOP_ASSERT_SVH
`define POLYNOMIAL_MAP_ORBIT_JACOBIAN_TOP_ASSERT_SVH
`define PMO_ASSERT_IMPL(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
`define PMO_ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== rtl/pmo_pkg.sv =====
`default_nettype none
package pmo_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned DimDefault = 2;
  localparam logic signed [31:0] OneQ = 32'sd16777216;
  localparam logic [2:0] RegA = 3'd0;
  localparam logic [2:0] RegB = 3'd1;
  localparam logic [2:0] RegC = 3'd2;
  localparam logic [2:0] RegD = 3'd3;
  localparam logic [2:0] RegM = 3'd4;
  localparam logic [2:0] RegIt = 3'd5;

  // shared ALU operations
  typedef enum logic [1:0] {OpMul, OpAdd, OpSub, OpMulInt} alu_op_e;

  typedef struct packed {
    alu_op_e op;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } alu_req_t;

  typedef struct packed {
    logic signed [31:0] r;
    logic sat;
  } alu_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/pmo_alu.sv =====
`default_nettype none
// Shared saturating Q8.24 unit: multiply, add, subtract, integer scale.
// Result registered.
module pmo_alu (
  input  wire logic clk_i,
  input  wire pmo_pkg::alu_req_t req_i,
  output pmo_pkg::alu_rsp_t rsp_o
);
  import pmo_pkg::*;
  logic signed [63:0] prod, wide;
  logic signed [31:0] r_d;
  logic sat_d;
  alu_rsp_t rsp_q;

  always_comb begin
    prod = 64'(req_i.x) * 64'(req_i.y);
    unique case (req_i.op)
      OpMul: wide = (prod + 64'sd8388608) >>> 24;
      OpAdd: wide = 64'(req_i.x) + 64'(req_i.y);
      OpSub: wide = 64'(req_i.x) - 64'(req_i.y);
      default: wide = prod;
    endcase
    sat_d = 1'b0;
    r_d = wide[31:0];
    if (wide > 64'sd2147483647) begin
      sat_d = 1'b1;
      r_d = 32'sh7fffffff;
    end else if (wide < -64'sd2147483648) begin
      sat_d = 1'b1;
      r_d = 32'sh80000000;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q.r <= r_d;
    rsp_q.sat <= sat_d;
  end
  assign rsp_o = rsp_q;
endmodule
`default_nettype wire

// ===== rtl/polynomial_map_orbit_jacobian_top.sv =====
`default_nettype none
// Channel   Dir  Beat
// s_axis    in   tdata = start_u, start_v
// m_axis    out  tdata = end_u..jac_vv, tuser = overflow
// cfg       in   index, 32-bit data
// Each ALU op is issued in StIssue and its registered result is taken in
// StWait; all ops of a point share the one multiplier in pmo_alu. Reset
// restores the register defaults. Input is not ready while a point runs or
// a result waits; a stalled result holds and the next point is taken once
// it leaves.
module polynomial_map_orbit_jacobian_top #(
  parameter int unsigned DIM = pmo_pkg::DimDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // start_u, start_v
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  output logic [191:0] m_axis_tdata,       // end_u, end_v, jac_uu, jac_uv, jac_vu, jac_vv
  output logic m_axis_tuser,               // overflow
  input  wire logic cfg_valid_i,
  output logic cfg_ready_o,
  input  wire logic [2:0] cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  import pmo_pkg::*;
  localparam int unsigned NJac = DIM * DIM;

  typedef enum logic [1:0] {StIdle, StIssue, StWait, StOut} state_e;
  state_e st_q;
  logic [4:0] step_q;
  logic [3:0] k_q;
  logic [7:0] it_q;
  logic signed [31:0] ca_q, cb_q, cc_q, cd_q;
  logic [3:0] pm_q;
  logic [7:0] itn_q;
  logic signed [31:0] u_q, v_q, pw_q, pw1_q, df_q, ap_q, nu_q, tmp_q, t0_q, g_q;
  logic signed [31:0] jac_q [NJac];
  logic ovf_q;
  alu_req_t req;
  alu_rsp_t rsp;

  pmo_alu u_alu (.clk_i(clk_i), .req_i(req), .rsp_o(rsp));

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = (st_q == StIdle);
  assign m_axis_tvalid = (st_q == StOut);
  assign m_axis_tuser = ovf_q;
  assign m_axis_tdata = {jac_q[3], jac_q[2], jac_q[1], jac_q[0], v_q, u_q};

  // step list: 0 pow loop, 1 u*u, 2 b*b, 3 diff, 4 a*pw, 5 d*v, 6 ap*diff,
  // 7 c*u, 8 nv, 9 pw1*m, 10 a*mq, 11 *diff, 12 u+u, 13 ap*2u, 14 t0+t1,
  // 15 g=+c, 16 d*r10, 17 d*r11, 18 g*r00, 19 g*r01
  always_comb begin
    req.op = OpMul;
    req.x = pw_q;
    req.y = u_q;
    unique case (step_q)
      5'd0: begin req.x = pw_q; req.y = u_q; end
      5'd1: begin req.x = u_q; req.y = u_q; end
      5'd2: begin req.x = cb_q; req.y = cb_q; end
      5'd3: begin req.op = OpSub; req.x = tmp_q; req.y = t0_q; end
      5'd4: begin req.x = ca_q; req.y = pw_q; end
      5'd5: begin req.x = cd_q; req.y = v_q; end
      5'd6: begin req.x = ap_q; req.y = df_q; end
      5'd7: begin req.x = cc_q; req.y = u_q; end
      5'd8: begin req.op = OpAdd; req.x = tmp_q; req.y = t0_q; end
      5'd9: begin req.op = OpMulInt; req.x = pw1_q; req.y = {28'd0, pm_q}; end
      5'd10: begin req.x = ca_q; req.y = t0_q; end
      5'd11: begin req.x = t0_q; req.y = df_q; end
      5'd12: begin req.op = OpAdd; req.x = u_q; req.y = u_q; end
      5'd13: begin req.x = ap_q; req.y = g_q; end
      5'd14: begin req.op = OpAdd; req.x = t0_q; req.y = g_q; end
      5'd15: begin req.op = OpAdd; req.x = g_q; req.y = cc_q; end
      5'd16: begin req.x = cd_q; req.y = jac_q[2]; end
      5'd17: begin req.x = cd_q; req.y = jac_q[3]; end
      5'd18: begin req.x = g_q; req.y = jac_q[0]; end
      5'd19: begin req.x = g_q; req.y = jac_q[1]; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      step_q <= '0;
      k_q <= '0;
      it_q <= '0;
      ovf_q <= 1'b0;
      ca_q <= '0;
      cb_q <= '0;
      cc_q <= '0;
      cd_q <= OneQ;
      pm_q <= 4'd1;
      itn_q <= 8'd1;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegA: ca_q <= cfg_data_i;
          RegB: cb_q <= cfg_data_i;
          RegC: cc_q <= cfg_data_i;
          RegD: cd_q <= cfg_data_i;
          RegM: pm_q <= cfg_data_i[3:0];
          RegIt: itn_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      unique case (st_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            u_q <= s_axis_tdata[31:0];
            v_q <= s_axis_tdata[63:32];
            jac_q[0] <= OneQ;
            jac_q[1] <= '0;
            jac_q[2] <= '0;
            jac_q[3] <= OneQ;
            ovf_q <= 1'b0;
            pw_q <= OneQ;
            pw1_q <= '0;
            k_q <= '0;
            it_q <= '0;
            step_q <= (pm_q == 4'd0) ? 5'd1 : 5'd0;
            st_q <= (itn_q == 8'd0) ? StOut : StIssue;
          end
        end
        StIssue: st_q <= StWait;
        StWait: begin
          st_q <= StIssue;
          ovf_q <= ovf_q | rsp.sat;
          step_q <= step_q + 5'd1;
          unique case (step_q)
            5'd0: begin
              pw1_q <= pw_q;
              pw_q <= rsp.r;
              k_q <= k_q + 4'd1;
              if (k_q + 4'd1 != pm_q) step_q <= 5'd0;
            end
            5'd1: tmp_q <= rsp.r;
            5'd2: t0_q <= rsp.r;
            5'd3: df_q <= rsp.r;
            5'd4: ap_q <= rsp.r;
            5'd5: nu_q <= rsp.r;
            5'd6: tmp_q <= rsp.r;
            5'd7: t0_q <= rsp.r;
            5'd8: begin
              v_q <= rsp.r;
              t0_q <= '0;
              if (pm_q == 4'd0) step_q <= 5'd12;
            end
            5'd9: t0_q <= rsp.r;
            5'd10: t0_q <= rsp.r;
            5'd11: t0_q <= rsp.r;
            5'd12: g_q <= rsp.r;
            5'd13: g_q <= rsp.r;
            5'd14: g_q <= rsp.r;
            5'd15: g_q <= rsp.r;
            5'd16: tmp_q <= rsp.r;
            5'd17: t0_q <= rsp.r;
            5'd18: jac_q[2] <= rsp.r;
            5'd19: begin
              jac_q[3] <= rsp.r;
              jac_q[0] <= tmp_q;
              jac_q[1] <= t0_q;
              u_q <= nu_q;
              pw_q <= OneQ;
              pw1_q <= '0;
              k_q <= '0;
              it_q <= it_q + 8'd1;
              step_q <= (pm_q == 4'd0) ? 5'd1 : 5'd0;
              if (it_q + 8'd1 == itn_q) st_q <= StOut;
            end
            default: ;
          endcase
        end
        StOut: if (m_axis_tready) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/pmo_checker.sv =====
`default_nettype none
`include "polynomial_map_orbit_jacobian_top_assert.svh"
// Port-level checks on the orbit block.
module pmo_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [191:0] m_axis_tdata
);
  // never ready for input while a result is shown
  `PMO_ASSERT_IMPL(a_excl, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  // an accepted point hides the ready
  `PMO_ASSERT_NEXT(a_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // stalled result holds
  `PMO_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind polynomial_map_orbit_jacobian_top pmo_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// ===== dv/pmo_orbit_checker.sv =====
`timescale 1ns / 100ps
// Watches the point, result and register channels, predicts each result and
// compares it with what the block returns.
module pmo_orbit_checker (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  input  logic s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic m_axis_tvalid,
  input  logic m_axis_tready,
  input  logic [191:0] m_axis_tdata,
  input  logic m_axis_tuser,
  input  logic cfg_valid_i,
  input  logic cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int errors_o,
  output int pending_o
);
  import pmo_pkg::*;

  typedef struct packed {
    logic        ovf;
    logic [31:0] jvv;
    logic [31:0] jvu;
    logic [31:0] juv;
    logic [31:0] juu;
    logic [31:0] ev;
    logic [31:0] eu;
  } orbit_res_t;

  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;

  // shadow copy of the map coefficients
  logic signed [31:0] k_a, k_b, k_c, k_d;
  logic [3:0] k_m;
  logic [7:0] k_it;
  logic sat_seen;

  orbit_res_t exp_q[$];
  int errors;

  function automatic logic signed [31:0] clamp(longint x);
    if (x > QMax) begin
      sat_seen = 1'b1;
      return 32'sh7fffffff;
    end
    if (x < QMin) begin
      sat_seen = 1'b1;
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  // Q8.24 product, round half up, floor shift
  function automatic logic signed [31:0] fmul(logic signed [31:0] x, logic signed [31:0] y);
    longint p;
    p = longint'(x) * longint'(y) + (64'sd1 <<< 23);
    return clamp(p >>> 24);
  endfunction

  function automatic logic signed [31:0] fadd(logic signed [31:0] x, logic signed [31:0] y);
    return clamp(longint'(x) + longint'(y));
  endfunction

  function automatic logic signed [31:0] fsub(logic signed [31:0] x, logic signed [31:0] y);
    return clamp(longint'(x) - longint'(y));
  endfunction

  function automatic orbit_res_t run_orbit(logic signed [31:0] su, logic signed [31:0] sv);
    logic signed [31:0] u, v, pm, pm1, diff, ap, g, nu, nv, t0, t1, mq;
    logic signed [31:0] r00, r01, r10, r11;
    orbit_res_t res;
    u = su;
    v = sv;
    r00 = OneQ;
    r01 = '0;
    r10 = '0;
    r11 = OneQ;
    sat_seen = 1'b0;
    for (int it = 0; it < int'(k_it); it++) begin
      pm = OneQ;
      pm1 = '0;
      for (int k = 0; k < int'(k_m); k++) begin
        pm1 = pm;
        pm = fmul(pm, u);
      end
      diff = fsub(fmul(u, u), fmul(k_b, k_b));
      ap = fmul(k_a, pm);
      nu = fmul(k_d, v);
      nv = fadd(fmul(ap, diff), fmul(k_c, u));
      // zero exponent drops the derivative term
      t0 = '0;
      if (k_m != 0) begin
        mq = clamp(longint'(pm1) * longint'(k_m));
        t0 = fmul(fmul(k_a, mq), diff);
      end
      t1 = fmul(ap, fadd(u, u));
      g = fadd(fadd(t0, t1), k_c);
      // R := J * R with J = [[0, d], [g, 0]]
      t0 = fmul(k_d, r10);
      t1 = fmul(k_d, r11);
      r10 = fmul(g, r00);
      r11 = fmul(g, r01);
      r00 = t0;
      r01 = t1;
      u = nu;
      v = nv;
    end
    res.eu = u;
    res.ev = v;
    res.juu = r00;
    res.juv = r01;
    res.jvu = r10;
    res.jvv = r11;
    res.ovf = sat_seen;
    return res;
  endfunction

  function automatic void note(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("%t mismatch %s: expected %h actual %h", $realtime, fname, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    orbit_res_t want;
    if (!rst_ni) begin
      k_a <= '0;
      k_b <= '0;
      k_c <= '0;
      k_d <= OneQ;
      k_m <= 4'd1;
      k_it <= 8'd1;
      pending_o <= 0;
    end else begin
      // register writes; unknown indexes are dropped
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegA:  k_a <= cfg_data_i;
          RegB:  k_b <= cfg_data_i;
          RegC:  k_c <= cfg_data_i;
          RegD:  k_d <= cfg_data_i;
          RegM:  k_m <= cfg_data_i[3:0];
          RegIt: k_it <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        exp_q.push_back(run_orbit(s_axis_tdata[31:0], s_axis_tdata[63:32]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (exp_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%t result beat with nothing expected", $realtime);
        end else begin
          want = exp_q.pop_front();
          note("end_u", want.eu, m_axis_tdata[31:0]);
          note("end_v", want.ev, m_axis_tdata[63:32]);
          note("jac_uu", want.juu, m_axis_tdata[95:64]);
          note("jac_uv", want.juv, m_axis_tdata[127:96]);
          note("jac_vu", want.jvu, m_axis_tdata[159:128]);
          note("jac_vv", want.jvv, m_axis_tdata[191:160]);
          note("overflow", {31'd0, want.ovf}, {31'd0, m_axis_tuser});
        end
      end
      // outstanding count after this edge's pushes and pops
      pending_o <= exp_q.size();
    end
  end

  initial errors = 0;
  assign errors_o = errors;
endmodule

// ===== dv/tb_polynomial_map_orbit_jacobian_top.sv =====
`timescale 1ns / 100ps
module tb_polynomial_map_orbit_jacobian_top;
  import pmo_pkg::*;

  localparam logic [2:0] RegNone6 = 3'd6;
  localparam logic [2:0] RegNone7 = 3'd7;
  localparam int StallLimit = 200000;
  localparam logic [31:0] QTwo = 32'd33554432;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  int errors, pending;
  int src_idle = 38, snk_idle = 76;
  bit snk_hold = 1'b0;
  int quiet = 0;

  always #4 clk = ~clk;

  polynomial_map_orbit_jacobian_top dut (
    .clk_i(clk), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  pmo_orbit_checker chk (
    .clk_i(clk), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .errors_o(errors), .pending_o(pending)
  );

  // result side backpressure
  always @(negedge clk) m_axis_tready <= !snk_hold && ($urandom_range(99) >= snk_idle);

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet <= 0;
    end else if (quiet >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_point(logic [31:0] u, logic [31:0] v);
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {v, u};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic end_points();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    end_points();
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk); while (!cfg_ready_o);
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_map(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d,
                         logic [3:0] m, logic [7:0] n);
    write_reg(RegA, a);
    write_reg(RegB, b);
    write_reg(RegC, c);
    write_reg(RegD, d);
    write_reg(RegM, {28'd0, m});
    write_reg(RegIt, {24'd0, n});
  endtask

  // mostly values near unity, sometimes full range or extremes
  function automatic logic [31:0] pick_q();
    case ($urandom_range(7))
      0: return $urandom;
      1: return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
      2: return '0;
      default: return $urandom_range(2 * QTwo) - QTwo;
    endcase
  endfunction

  initial begin
    int total;
    int per;
    logic [3:0] m;
    logic [7:0] n;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // reset coefficients, field extremes
    send_point('0, '0);
    send_point(32'h7fffffff, 32'h80000000);
    send_point(32'h80000000, 32'h7fffffff);
    send_point(32'h01000000, 32'hff000000);
    drain();
    // ignored indexes leave the map untouched
    write_reg(RegNone6, 32'hffffffff);
    write_reg(RegNone7, 32'h12345678);
    send_point(32'h00800000, 32'h01800000);
    drain();
    // zero exponent
    set_map(32'h01000000, 32'h00800000, 32'h00400000, 32'h01000000, 4'd0, 8'd3);
    send_point(32'h00c00000, 32'hff400000);
    send_point(32'hffffffff, 32'h00000001);
    drain();
    // zero iterations
    write_reg(RegIt, 32'd0);
    send_point(32'h7fffffff, 32'h80000000);
    send_point(32'h12345678, 32'h9abcdef0);
    drain();
    // coefficient extremes, heavy saturation
    set_map(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 4'd15, 8'd4);
    send_point(32'h7fffffff, 32'h7fffffff);
    send_point(32'h80000000, 32'h00000000);
    drain();
    set_map(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 4'd2, 8'd2);
    send_point(32'h02000000, 32'hfe000000);
    send_point(32'h00000001, 32'hffffffff);
    drain();
    // longest run
    set_map(32'h00100000, 32'h00800000, 32'h00c00000, 32'h00f00000, 4'd15, 8'd255);
    send_point(32'h00400000, 32'h00200000);
    send_point(32'hfff00000, 32'h00080000);
    drain();

    total = 0;
    for (int ph = 0; ph < 22; ph++) begin
      if (ph == 7) begin
        src_idle = 76;
        snk_idle = 38;
      end else if (ph == 14) begin
        src_idle = 0;
        snk_idle = 0;
      end
      m = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
      n = ($urandom_range(5) == 0) ? 8'($urandom_range(20)) : 8'($urandom_range(1, 5));
      set_map(pick_q(), pick_q(), pick_q(), pick_q(), m, n);
      // long receiver hold while points keep being offered
      if (ph == 15) begin
        fork
          begin
            @(negedge clk);
            snk_hold = 1'b1;
            repeat (3000) @(posedge clk);
            snk_hold = 1'b0;
          end
        join_none
      end
      per = 53;
      for (int i = 0; i < per; i++) begin
        if ($urandom_range(2) == 0) send_point($urandom, $urandom);
        else send_point(pick_q(), pick_q());
        total++;
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
